// ----- hdl/mts_pkg.sv -----
// ----------------------------------------------------------------------------
// mts_pkg
// Shared types and codes for the min tracking stack.
// ----------------------------------------------------------------------------
package mts_pkg;

    localparam int VALUE_W  = 32;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;

    localparam logic [MODE_W-1:0] MODE_PUSH = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MIN  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic accept;
        logic load_top;
    } cmd_t;

    typedef struct packed {
        logic pop_ok;
        logic empty;
    } stat_t;

endpackage

// ----- hdl/mts_if.sv -----
// ----------------------------------------------------------------------------
// mts_in_if / mts_out_if
// Valid/ready channels for operation items and result items.
// ----------------------------------------------------------------------------
interface mts_in_if;
    logic                                    valid;
    logic                                    ready;
    logic        [mts_pkg::MODE_W-1:0]       mode;
    logic signed [mts_pkg::VALUE_W-1:0]      value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

interface mts_out_if #(parameter int OCC_W = 11);
    logic                                    valid;
    logic                                    ready;
    logic signed [mts_pkg::VALUE_W-1:0]      result_value;
    logic        [mts_pkg::STATUS_W-1:0]     status;
    logic        [OCC_W-1:0]                 occupancy;

    modport source (output valid, output result_value, output status, output occupancy,
                    input ready);
    modport sink   (input valid, input result_value, input status, input occupancy,
                    output ready);
endinterface

// ----- hdl/mts_ram.sv -----
// ----------------------------------------------------------------------------
// mts_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mts_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/mts_datapath.sv -----
// ----------------------------------------------------------------------------
// mts_datapath
// Fill count, cached top entry and running minimum, entry memory, result register.
// ----------------------------------------------------------------------------
module mts_datapath #(
    parameter int DEPTH = 1024
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  mts_pkg::cmd_t                          cmd,
    output mts_pkg::stat_t                         stat,
    input  logic        [mts_pkg::MODE_W-1:0]      mode,
    input  logic signed [mts_pkg::VALUE_W-1:0]     value,
    output logic signed [mts_pkg::VALUE_W-1:0]     result_value,
    output logic        [mts_pkg::STATUS_W-1:0]    status,
    output logic        [$clog2(DEPTH+1)-1:0]      occupancy
);

    localparam int OCC_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int VW     = mts_pkg::VALUE_W;

    logic        [OCC_W-1:0]              fill_reg, fill_next;
    logic signed [VW-1:0]                 top_val_reg, top_val_next;
    logic signed [VW-1:0]                 top_min_reg, top_min_next;
    logic signed [VW-1:0]                 res_reg, res_next;
    logic        [mts_pkg::STATUS_W-1:0]  status_reg, status_next;
    logic        [OCC_W-1:0]              occ_reg, occ_next;

    logic                                 full, empty;
    logic signed [VW-1:0]                 run_min;
    logic                                 we;
    logic        [ADDR_W-1:0]             raddr;
    logic        [2*VW-1:0]               rdata;

    assign full  = (fill_reg == OCC_W'(DEPTH));
    assign empty = (fill_reg == '0);
    assign run_min = (!empty && (top_min_reg < value)) ? top_min_reg : value;
    assign raddr = fill_reg[ADDR_W-1:0] - ADDR_W'(2);

    assign stat.pop_ok = (mode == mts_pkg::MODE_POP) && !empty;
    assign stat.empty  = empty;

    always_comb
    begin
        fill_next    = fill_reg;
        top_val_next = top_val_reg;
        top_min_next = top_min_reg;
        res_next     = res_reg;
        status_next  = status_reg;
        occ_next     = occ_reg;
        we           = 1'b0;
        if (cmd.load_top)
        begin
            top_val_next = rdata[2*VW-1:VW];
            top_min_next = rdata[VW-1:0];
        end
        if (cmd.accept)
        begin
            res_next    = '0;
            status_next = mts_pkg::STATUS_OK;
            case (mode)
                mts_pkg::MODE_PUSH:
                begin
                    if (full)
                    begin
                        status_next = mts_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        we           = 1'b1;
                        top_val_next = value;
                        top_min_next = run_min;
                        fill_next    = fill_reg + OCC_W'(1);
                    end
                end
                mts_pkg::MODE_POP:
                begin
                    if (empty)
                    begin
                        status_next = mts_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        res_next  = top_val_reg;
                        fill_next = fill_reg - OCC_W'(1);
                    end
                end
                mts_pkg::MODE_MIN:
                begin
                    if (empty)
                    begin
                        status_next = mts_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        res_next = top_min_reg;
                    end
                end
                default:
                begin
                    res_next = '0;
                end
            endcase
            occ_next = fill_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_val_reg <= top_val_next;
        top_min_reg <= top_min_next;
        res_reg     <= res_next;
        status_reg  <= status_next;
        occ_reg     <= occ_next;
    end

    mts_ram #(
        .WIDTH (2 * VW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (fill_reg[ADDR_W-1:0]),
        .wdata ({value, run_min}),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign result_value = res_reg;
    assign status       = status_reg;
    assign occupancy    = occ_reg;

endmodule

// ----- hdl/mts_ctrl.sv -----
// ----------------------------------------------------------------------------
// mts_ctrl
// Handshake control and top-refetch sequencing for the min tracking stack.
// ----------------------------------------------------------------------------
module mts_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    output mts_pkg::cmd_t  cmd,
    input  mts_pkg::stat_t stat
);

    localparam logic ST_RUN  = 1'b0;
    localparam logic ST_LOAD = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic accept;

    assign in_ready = (state_reg == ST_RUN) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    assign cmd.accept   = accept;
    assign cmd.load_top = (state_reg == ST_LOAD);

    always_comb
    begin
        state_next     = ST_RUN;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (accept)
        begin
            out_valid_next = 1'b1;
            if (stat.pop_ok)
            begin
                state_next = ST_LOAD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_load_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LOAD |=> state_reg == ST_RUN)
        else $error("top refetch lasted more than one cycle");

    a_no_accept_in_load: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LOAD |-> !accept)
        else $error("item accepted during top refetch");

    a_pop_refetch: assert property (@(posedge clk) disable iff (!rst_n)
        accept && stat.pop_ok |=> state_reg == ST_LOAD && out_valid_reg)
        else $error("pop did not start top refetch");

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        stat.pop_ok |-> !stat.empty)
        else $error("pop flagged ok on empty stack");

endmodule

// ----- hdl/min_tracking_stack.sv -----
// ----------------------------------------------------------------------------
// min_tracking_stack
// Bounded stack of signed 32-bit values with constant-time minimum query.
// ----------------------------------------------------------------------------
// Each item on req is one operation (push, pop, min) and gives exactly one
// item on rsp with a value, a status and the occupancy after the operation.
// The top entry and its running minimum are cached in registers; a
// successful pop is followed by a refetch state, with req held off, as the
// new top is fetched back through the registered read port of the entry memory.
// The result register is reloaded in the cycle its item leaves, so items
// follow back to back while rsp is ready, apart from the pop refetch; while
// a result waits on rsp, req is held off. No clearing pass is needed after
// reset. Instantiate rsp with OCC_W = $clog2(DEPTH+1).
// ----------------------------------------------------------------------------
module min_tracking_stack #(
    parameter int DEPTH = 1024
) (
    input  logic       clk,
    input  logic       rst_n,
    mts_in_if.sink     req,
    mts_out_if.source  rsp
);

    mts_pkg::cmd_t  cmd;
    mts_pkg::stat_t stat;

    mts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    mts_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .mode         (req.mode),
        .value        (req.value),
        .result_value (rsp.result_value),
        .status       (rsp.status),
        .occupancy    (rsp.occupancy)
    );

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Checks the min tracking stack against a cycle-free predictor of its contents.
// Directed push, pop and min items cover the signed extremes, the empty
// stack and the unused mode. A fill test pushes to full under a long
// receiver hold-off, then overflows and drains half the stack. Random phases
// then alternate push-heavy and pop-heavy stretches under changing idle rates
// on both channels. Every result item is compared field by field in order.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = 1024;
    localparam int OCC_W       = $clog2(DEPTH + 1);
    localparam int CYCLE_LIMIT = 400000;

    localparam logic [mts_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic signed [mts_pkg::VALUE_W-1:0]  value;
        logic        [mts_pkg::STATUS_W-1:0] status;
        logic        [OCC_W-1:0]             occupancy;
    } reply_t;

    logic clk;
    logic rst_n;

    mts_in_if                  req ();
    mts_out_if #(.OCC_W(OCC_W)) rsp ();

    min_tracking_stack #(
        .DEPTH (DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    logic signed [mts_pkg::VALUE_W-1:0] shadow_vals [DEPTH];
    logic signed [mts_pkg::VALUE_W-1:0] shadow_mins [DEPTH];
    int unsigned                        shadow_fill;
    reply_t                             replies_due [$];

    int src_idle_pct;
    int sink_idle_pct;
    int hold_request;
    int hold_left;
    int unsigned cycle_count;
    int unsigned failures;
    int unsigned items_sent;
    int unsigned replies_checked;
    int unsigned full_hits;
    int unsigned empty_hits;
    int unsigned peak_fill;

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            rsp.ready <= 1'b0;
            hold_left--;
        end
        else
        begin
            rsp.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    function automatic reply_t apply_stack_op(logic [mts_pkg::MODE_W-1:0] op,
                                              logic signed [mts_pkg::VALUE_W-1:0] v);
        reply_t                             r;
        logic signed [mts_pkg::VALUE_W-1:0] run;
        r.value  = '0;
        r.status = mts_pkg::STATUS_OK;
        case (op)
            mts_pkg::MODE_PUSH:
            begin
                if (shadow_fill >= DEPTH)
                begin
                    r.status = mts_pkg::STATUS_FULL;
                end
                else
                begin
                    run = v;
                    if (shadow_fill > 0 && shadow_mins[shadow_fill - 1] < v)
                    begin
                        run = shadow_mins[shadow_fill - 1];
                    end
                    shadow_vals[shadow_fill] = v;
                    shadow_mins[shadow_fill] = run;
                    shadow_fill++;
                end
            end
            mts_pkg::MODE_POP:
            begin
                if (shadow_fill == 0)
                begin
                    r.status = mts_pkg::STATUS_EMPTY;
                end
                else
                begin
                    shadow_fill--;
                    r.value = shadow_vals[shadow_fill];
                end
            end
            mts_pkg::MODE_MIN:
            begin
                if (shadow_fill == 0)
                begin
                    r.status = mts_pkg::STATUS_EMPTY;
                end
                else
                begin
                    r.value = shadow_mins[shadow_fill - 1];
                end
            end
            default:
            begin
            end
        endcase
        r.occupancy = shadow_fill[OCC_W-1:0];
        return r;
    endfunction

    always @(posedge clk)
    begin
        reply_t exp_r;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (replies_due.size() == 0)
            begin
                $error("unexpected result item: value %0d status %0d occupancy %0d",
                       rsp.result_value, rsp.status, rsp.occupancy);
                failures++;
            end
            else
            begin
                exp_r = replies_due.pop_front();
                replies_checked++;
                if (rsp.result_value !== exp_r.value)
                begin
                    $error("result_value: expected %0d, actual %0d",
                           exp_r.value, rsp.result_value);
                    failures++;
                end
                if (rsp.status !== exp_r.status)
                begin
                    $error("status: expected %0d, actual %0d", exp_r.status, rsp.status);
                    failures++;
                end
                if (rsp.occupancy !== exp_r.occupancy)
                begin
                    $error("occupancy: expected %0d, actual %0d",
                           exp_r.occupancy, rsp.occupancy);
                    failures++;
                end
            end
        end
    end

    // entered and left at a falling edge; valid stays high between items unless an idle gap is drawn
    task automatic send_op(logic [mts_pkg::MODE_W-1:0] op,
                           logic signed [mts_pkg::VALUE_W-1:0] v);
        reply_t r;
        while ($urandom_range(99) < src_idle_pct)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid <= 1'b1;
        req.mode  <= op;
        req.value <= v;
        do
            @(posedge clk);
        while (!req.ready);
        r = apply_stack_op(op, v);
        replies_due.push_back(r);
        items_sent++;
        if (r.status == mts_pkg::STATUS_FULL)
        begin
            full_hits++;
        end
        if (r.status == mts_pkg::STATUS_EMPTY)
        begin
            empty_hits++;
        end
        if (shadow_fill > peak_fill)
        begin
            peak_fill = shadow_fill;
        end
        @(negedge clk);
    endtask

    task automatic wait_drained();
        req.valid <= 1'b0;
        while (replies_due.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    function automatic logic signed [mts_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(7))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return '0;
            3: return -32'sd1;
            4: return $signed($urandom_range(20)) - 32'sd10;
            default: return $signed($urandom);
        endcase
    endfunction

    task automatic test_directed();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        send_op(mts_pkg::MODE_MIN, 32'sd0);
        send_op(mts_pkg::MODE_POP, 32'sd0);
        send_op(MODE_UNUSED, 32'sh7fff_ffff);
        send_op(mts_pkg::MODE_PUSH, 32'sh7fff_ffff);
        send_op(mts_pkg::MODE_MIN, 32'sd0);
        send_op(mts_pkg::MODE_PUSH, 32'sh8000_0000);
        send_op(mts_pkg::MODE_MIN, 32'sd0);
        send_op(mts_pkg::MODE_PUSH, 32'sd0);
        send_op(mts_pkg::MODE_MIN, 32'sd0);
        send_op(mts_pkg::MODE_POP, 32'sd0);
        send_op(mts_pkg::MODE_MIN, 32'sd0);
        send_op(mts_pkg::MODE_POP, 32'sd0);
        send_op(mts_pkg::MODE_MIN, 32'sd0);
        send_op(mts_pkg::MODE_POP, 32'sd0);
        send_op(mts_pkg::MODE_POP, 32'sd0);
        send_op(mts_pkg::MODE_PUSH, -32'sd1);
        send_op(mts_pkg::MODE_PUSH, 32'sd5);
        send_op(MODE_UNUSED, 32'sh8000_0000);
        send_op(mts_pkg::MODE_MIN, 32'sd0);
        send_op(mts_pkg::MODE_PUSH, -32'sd1);
        send_op(mts_pkg::MODE_POP, 32'sd0);
        send_op(mts_pkg::MODE_POP, 32'sd0);
        send_op(mts_pkg::MODE_POP, 32'sd0);
        send_op(mts_pkg::MODE_MIN, 32'sd0);
        wait_drained();
    endtask

    // hold the receiver so the block stalls its input, then fill, overflow,
    // drain half
    task automatic test_fill_overflow();
        int i;
        src_idle_pct  = 0;
        sink_idle_pct = 20;
        hold_request  = 400;
        for (i = 0; i < DEPTH; i++)
        begin
            send_op(mts_pkg::MODE_PUSH, pick_value());
        end
        send_op(mts_pkg::MODE_PUSH, 32'sh8000_0000);
        send_op(mts_pkg::MODE_MIN, 32'sd0);
        send_op(mts_pkg::MODE_PUSH, 32'sh7fff_ffff);
        send_op(MODE_UNUSED, 32'sd0);
        for (i = 0; i < DEPTH / 2; i++)
        begin
            if (i % 97 == 0)
            begin
                send_op(mts_pkg::MODE_MIN, 32'sd0);
            end
            send_op(mts_pkg::MODE_POP, 32'sd0);
        end
        send_op(mts_pkg::MODE_POP, 32'sd0);
        send_op(mts_pkg::MODE_MIN, 32'sd0);
        wait_drained();
    endtask

    task automatic test_random_ops(int n_items, int src_pct, int snk_pct);
        int                         i;
        int                         r;
        int                         push_pct;
        logic [mts_pkg::MODE_W-1:0] op;
        src_idle_pct  = src_pct;
        sink_idle_pct = snk_pct;
        push_pct      = 65;
        for (i = 0; i < n_items; i++)
        begin
            if (i % 64 == 63)
            begin
                push_pct = (push_pct == 65) ? 25 : 65;
            end
            r = $urandom_range(99);
            if (r < 5)
            begin
                op = MODE_UNUSED;
            end
            else if (r < 5 + push_pct)
            begin
                op = mts_pkg::MODE_PUSH;
            end
            else if (r < 5 + push_pct + (95 - push_pct) * 2 / 3)
            begin
                op = mts_pkg::MODE_POP;
            end
            else
            begin
                op = mts_pkg::MODE_MIN;
            end
            send_op(op, pick_value());
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        req.valid     = 1'b0;
        req.mode      = mts_pkg::MODE_PUSH;
        req.value     = '0;
        rsp.ready     = 1'b0;
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        hold_request  = 0;
        hold_left     = 0;
        shadow_fill   = 0;
        cycle_count   = 0;
        failures      = 0;
        items_sent    = 0;
        replies_checked = 0;
        full_hits     = 0;
        empty_hits    = 0;
        peak_fill     = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_fill_overflow();
        test_random_ops(150, 32, 74);
        test_random_ops(150, 74, 32);
        test_random_ops(150, 0, 0);

        repeat (20) @(negedge clk);
        if (replies_due.size() != 0)
        begin
            $error("%0d result items never arrived", replies_due.size());
            failures++;
        end
        $display("Sent %0d items, checked %0d results, peak depth %0d of %0d",
                 items_sent, replies_checked, peak_fill, DEPTH);
        $display("Pushes refused when full: %0d, pops or mins on empty: %0d",
                 full_hits, empty_hits);
        if (failures == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
